// ===== hdl/okss_pkg.sv =====
// shared types and constants for the ordered key set
`default_nettype none

package okss_pkg;

  localparam int KEY_BITS  = 12;
  localparam int DATA_BITS = 32;
  localparam int OP_BITS   = 3;

  // presence bitmap geometry: 64-bit words, one summary bit per word
  localparam int SCAN_W   = 64;
  localparam int POS_BITS = 6;
  localparam int WORD_AW  = (KEY_BITS > POS_BITS) ? KEY_BITS - POS_BITS : 1;
  localparam int SUM_AW   = (KEY_BITS > 2 * POS_BITS) ? KEY_BITS - 2 * POS_BITS : 1;
  localparam int WX       = SUM_AW + POS_BITS;
  localparam int EK       = SUM_AW + 2 * POS_BITS;

  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_MEMBER = 3'd2;
  localparam logic [OP_BITS-1:0] OP_MIN    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_MAX    = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SUCC   = 3'd5;
  localparam logic [OP_BITS-1:0] OP_PRED   = 3'd6;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [KEY_BITS-1:0]  answer_key;
    logic [DATA_BITS-1:0] answer_data;
  } rsp_t;

  typedef struct packed {
    logic [SCAN_W-1:0]   word;
    logic [POS_BITS-1:0] pos;
    logic                down;
  } scan_req_t;

  typedef struct packed {
    logic                hit;
    logic [POS_BITS-1:0] idx;
  } scan_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/okss_ram.sv =====
// simple dual-port ram with registered read
`default_nettype none

module okss_ram import okss_pkg::*; #(
  parameter int AW    = KEY_BITS,
  parameter int WIDTH = DATA_BITS
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/okss_scan.sv =====
// shared bit scanner: nearest set bit at or above / at or below a position
`default_nettype none

module okss_scan import okss_pkg::*; (
  input  wire scan_req_t sreq,
  output scan_rsp_t      srsp
);

  logic [SCAN_W-1:0]   m;
  logic [POS_BITS-1:0] lo_idx;
  logic [POS_BITS-1:0] hi_idx;

  always_comb begin
    m      = '0;
    lo_idx = '0;
    hi_idx = '0;
    for (int i = 0; i < SCAN_W; i++) begin
      m[i] = sreq.word[i] && (sreq.down ? (POS_BITS'(i) <= sreq.pos)
                                        : (POS_BITS'(i) >= sreq.pos));
    end
    for (int j = SCAN_W - 1; j >= 0; j--) begin
      if (m[j]) lo_idx = POS_BITS'(j);
    end
    for (int j = 0; j < SCAN_W; j++) begin
      if (m[j]) hi_idx = POS_BITS'(j);
    end
  end

  assign srsp.hit = |m;
  assign srsp.idx = sreq.down ? hi_idx : lo_idx;

endmodule

`default_nettype wire

// ===== hdl/ordered_key_set_with_successor.sv =====
// ordered key set: bitmap words plus summary, one shared bit scanner
// insert, delete, member: one transaction at a time, req_stall high until the result is loaded
// search: a hit in the query's own word needs no summary step; otherwise the summary is scanned,
// stepping on through further summary words until a set bit or the end of the summary is reached
// rate is set by the single scanner, the registered read of the bitmap rams and rsp_stall
// after reset a clearing pass over all 2^(KEY_BITS-6) bitmap words (64) holds stall high
`default_nettype none

module ordered_key_set_with_successor import okss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire logic req_valid,
  output logic      req_stall,
  output rsp_t      rsp,
  output logic      rsp_valid,
  input  wire logic rsp_stall
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WORD, ST_SUM, ST_CW2, ST_DATA, ST_DONE
  } state_t;

  state_t state;

  logic [OP_BITS-1:0]   op_r;
  logic [KEY_BITS-1:0]  q_r;
  logic                 down_r;
  logic [DATA_BITS-1:0] pay_r;
  logic [WX-1:0]        cur_w;
  logic [SUM_AW-1:0]    sidx_r;
  logic [POS_BITS-1:0]  spos;
  logic [WORD_AW-1:0]   clr;
  rsp_t                 res;

  // request decode
  logic [KEY_BITS-1:0] q_in;
  logic                down_in;
  logic                none_in;
  logic [EK-1:0]       qe_in;

  always_comb begin
    q_in    = req.key;
    down_in = 1'b0;
    none_in = 1'b0;
    unique case (req.op)
      OP_INSERT, OP_DELETE, OP_MEMBER: begin
      end
      OP_MIN: begin
        q_in = '0;
      end
      OP_MAX: begin
        q_in    = '1;
        down_in = 1'b1;
      end
      OP_SUCC: begin
        q_in    = req.key + KEY_BITS'(1);
        none_in = &req.key;
      end
      OP_PRED: begin
        q_in    = req.key - KEY_BITS'(1);
        down_in = 1'b1;
        none_in = (req.key == '0);
      end
      default: begin
        none_in = 1'b1;
      end
    endcase
  end

  assign qe_in = EK'(q_in);

  // fields of the latched query
  logic [EK-1:0]       qe;
  logic [WX-1:0]       qw;
  logic [POS_BITS-1:0] qbit;
  logic [SUM_AW-1:0]   qsidx;
  logic [POS_BITS-1:0] qsbit;

  assign qe    = EK'(q_r);
  assign qw    = qe[EK-1:POS_BITS];
  assign qbit  = qe[POS_BITS-1:0];
  assign qsidx = qe[EK-1:2*POS_BITS];
  assign qsbit = qe[2*POS_BITS-1:POS_BITS];

  // memories
  logic               c_we, c_re, s_we, s_re, d_we, d_re;
  logic [WORD_AW-1:0] c_waddr, c_raddr;
  logic [SCAN_W-1:0]  c_wdata, c_rdata;
  logic [SUM_AW-1:0]  s_waddr, s_raddr;
  logic [SCAN_W-1:0]  s_wdata, s_rdata;
  logic [KEY_BITS-1:0]  d_waddr, d_raddr;
  logic [DATA_BITS-1:0] d_wdata, d_rdata;

  okss_ram #(.AW(WORD_AW), .WIDTH(SCAN_W)) u_cluster (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  okss_ram #(.AW(SUM_AW), .WIDTH(SCAN_W)) u_summary (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  okss_ram #(.AW(KEY_BITS), .WIDTH(DATA_BITS)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );

  // shared scanner
  scan_req_t sreq;
  scan_rsp_t srsp;

  okss_scan u_scan (
    .sreq(sreq),
    .srsp(srsp)
  );

  always_comb begin
    sreq.word = c_rdata;
    sreq.pos  = qbit;
    sreq.down = down_r;
    if (state == ST_SUM) begin
      sreq.word = s_rdata;
      sreq.pos  = spos;
    end else if (state == ST_CW2) begin
      sreq.pos = down_r ? '1 : '0;
    end
  end

  // answer key from word index and scanned bit
  logic [EK-1:0]       ans_ext;
  logic [KEY_BITS-1:0] ans_key;
  logic [WX-1:0]       ans_w;

  assign ans_w   = (state == ST_CW2) ? cur_w : qw;
  assign ans_ext = {ans_w, srsp.idx};
  assign ans_key = ans_ext[KEY_BITS-1:0];

  // bitmap updates and summary stepping
  logic              present;
  logic [SCAN_W-1:0] bit_mask, sbit_mask;
  logic [SCAN_W-1:0] cw_set, cw_clr, sw_set, sw_clr;
  logic [SUM_AW-1:0] sidx_cur, sidx_step;
  logic              at_word_edge, sidx_edge;

  assign present   = c_rdata[qbit];
  assign bit_mask  = SCAN_W'(1) << qbit;
  assign sbit_mask = SCAN_W'(1) << qsbit;
  assign cw_set    = c_rdata | bit_mask;
  assign cw_clr    = c_rdata & ~bit_mask;
  assign sw_set    = s_rdata | sbit_mask;
  assign sw_clr    = s_rdata & ~sbit_mask;

  assign at_word_edge = down_r ? (qsbit == '0) : (&qsbit);
  assign sidx_cur     = (state == ST_WORD) ? qsidx : sidx_r;
  assign sidx_edge    = down_r ? (sidx_cur == '0) : (&sidx_cur);
  assign sidx_step    = down_r ? sidx_cur - SUM_AW'(1) : sidx_cur + SUM_AW'(1);

  logic [WX-1:0] nw;
  assign nw = {sidx_r, srsp.idx};

  always_comb begin
    c_we    = 1'b0;
    c_waddr = qw[WORD_AW-1:0];
    c_wdata = cw_set;
    c_re    = 1'b0;
    c_raddr = qw[WORD_AW-1:0];
    s_we    = 1'b0;
    s_waddr = qsidx;
    s_wdata = sw_set;
    s_re    = 1'b0;
    s_raddr = sidx_step;
    d_we    = 1'b0;
    d_waddr = q_r;
    d_wdata = pay_r;
    d_re    = 1'b0;
    d_raddr = ans_key;
    unique case (state)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr;
        c_wdata = '0;
        s_we    = 1'b1;
        s_waddr = clr[SUM_AW-1:0];
        s_wdata = '0;
      end
      ST_IDLE: begin
        if (req_valid && !none_in) begin
          c_re    = 1'b1;
          c_raddr = qe_in[POS_BITS +: WORD_AW];
          s_re    = 1'b1;
          s_raddr = qe_in[EK-1:2*POS_BITS];
          d_re    = 1'b1;
          d_raddr = q_in;
        end
      end
      ST_WORD: begin
        unique case (op_r)
          OP_INSERT: begin
            c_we = 1'b1;
            s_we = 1'b1;
            d_we = 1'b1;
          end
          OP_DELETE: begin
            if (present) begin
              c_we    = 1'b1;
              c_wdata = cw_clr;
              if (cw_clr == '0) begin
                s_we    = 1'b1;
                s_wdata = sw_clr;
              end
            end
          end
          OP_MEMBER: begin
          end
          default: begin
            if (srsp.hit) begin
              d_re = 1'b1;
            end else if (at_word_edge && !sidx_edge) begin
              s_re = 1'b1;
            end
          end
        endcase
      end
      ST_SUM: begin
        if (srsp.hit) begin
          c_re    = 1'b1;
          c_raddr = nw[WORD_AW-1:0];
        end else if (!sidx_edge) begin
          s_re = 1'b1;
        end
      end
      ST_CW2: begin
        d_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // load a new result or retire the one just taken
      if (state == ST_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + WORD_AW'(1);
          if (&clr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op_r   <= req.op;
            q_r    <= q_in;
            down_r <= down_in;
            pay_r  <= req.payload;
            res    <= '0;
            state  <= none_in ? ST_DONE : ST_WORD;
          end
        end
        ST_WORD: begin
          unique case (op_r)
            OP_INSERT, OP_DELETE, OP_MEMBER: begin
              res.found       <= present;
              res.answer_key  <= present ? q_r : '0;
              res.answer_data <= present ? d_rdata : '0;
              state           <= ST_DONE;
            end
            default: begin
              if (srsp.hit) begin
                res.answer_key <= ans_key;
                state          <= ST_DATA;
              end else if (!at_word_edge) begin
                // rest of the current summary word, already read
                sidx_r <= qsidx;
                spos   <= down_r ? qsbit - POS_BITS'(1) : qsbit + POS_BITS'(1);
                state  <= ST_SUM;
              end else if (!sidx_edge) begin
                sidx_r <= sidx_step;
                spos   <= down_r ? '1 : '0;
                state  <= ST_SUM;
              end else begin
                state <= ST_DONE;
              end
            end
          endcase
        end
        ST_SUM: begin
          if (srsp.hit) begin
            cur_w <= nw;
            state <= ST_CW2;
          end else if (!sidx_edge) begin
            sidx_r <= sidx_step;
            spos   <= down_r ? '1 : '0;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_CW2: begin
          // summary bit set means the word is non-empty, so this scan hits
          res.answer_key <= ans_key;
          state          <= ST_DATA;
        end
        ST_DATA: begin
          res.found       <= 1'b1;
          res.answer_data <= d_rdata;
          state           <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
